// ===== hdl/manchester_frame_encoder_macros.svh =====
// Assertion helpers for the RTL. Clock and reset are clk and rst_n.
`ifndef MANCHESTER_FRAME_ENCODER_MACROS_SVH
`define MANCHESTER_FRAME_ENCODER_MACROS_SVH

// Same-cycle implication.
`define MFE_ASSERT_NOW(label, cond, expect_now, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expect_now)) \
    else $error(msg);

// Next-cycle implication.
`define MFE_ASSERT_NEXT(label, cond, expect_next, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expect_next)) \
    else $error(msg);

`endif

// ===== hdl/mfe_pkg.sv =====
package mfe_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [7:0] CFG_IDX_PREAMBLE   = 8'd0;
  localparam logic [7:0] CFG_IDX_DELIMITER  = 8'd1;
  localparam logic [7:0] CFG_IDX_TYPE_FLAGS = 8'd2;
  localparam logic [7:0] CFG_IDX_MSG_LEN    = 8'd3;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  typedef struct packed {
    logic [7:0] preamble;
    logic [7:0] delimiter;
    logic [7:0] type_flags;
    logic [7:0] msg_len;
  } mfe_cfg_t;

  // One classified payload beat, handed from front to back.
  typedef struct packed {
    logic [7:0]  payload;
    logic        hdr;
    logic        tail;
    logic [15:0] crc;
  } mfe_job_t;

  function automatic logic [7:0] eff_len(input logic [7:0] len);
    eff_len = (len == 8'd0) ? 8'd1 : len;
  endfunction

  // 1 -> 10, 0 -> 01, bit k lands at pair 2k+1..2k.
  function automatic logic [7:0] manch_nibble(input logic [3:0] nib);
    logic [7:0] r;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      r[2*k+1] = nib[k];
      r[2*k]   = ~nib[k];
    end
    manch_nibble = r;
  endfunction

  // CRC-16/CCITT-FALSE byte update, poly 0x1021, no reflection.
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = {crc[7:0], crc[15:8]};
    c = c ^ {8'd0, b};
    c = c ^ {12'd0, c[7:4]};
    c = c ^ {c[3:0], 12'd0};
    c = c ^ {3'd0, c[7:0], 5'd0};
    crc_update = c;
  endfunction

endpackage

// ===== hdl/manchester_frame_encoder.sv =====
// Manchester frame encoder: each payload byte pushed in becomes Manchester coded
// frame bytes, two output beats per frame byte (upper nibble first, 1 -> 10,
// 0 -> 01, pairs LSB first). The first byte of a frame also emits preamble,
// delimiter, type/flags and length; the last one also emits the CRC-16/CCITT-FALSE
// (high then low) and the closing delimiter, flagged by out_frame_end. out_run_last
// marks the final beat caused by each input byte. The back-end sequencer emits one
// output beat per cycle while the receiver keeps popping, so a byte yields 2 beats mid-frame,
// 10 for the first, 8 for the last and 16 for a one-byte frame; a 4-entry queue lets
// the input run ahead by up to four bytes plus the one in flight. Register 3
// (message_length) of 0 acts as 1. Write configuration only while the block is drained.
`include "manchester_frame_encoder_macros.svh"

module manchester_frame_encoder import mfe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_payload_byte,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_encoded_byte,
  output logic       out_run_last,
  output logic       out_frame_end,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  mfe_cfg_t cfg_r;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;
  mfe_job_t q_wdata;
  mfe_job_t q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.preamble   <= 8'h55;
      cfg_r.delimiter  <= 8'h7E;
      cfg_r.type_flags <= 8'h00;
      cfg_r.msg_len    <= 8'd1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_IDX_PREAMBLE:   cfg_r.preamble   <= cfg_wdata;
        CFG_IDX_DELIMITER:  cfg_r.delimiter  <= cfg_wdata;
        CFG_IDX_TYPE_FLAGS: cfg_r.type_flags <= cfg_wdata;
        CFG_IDX_MSG_LEN:    cfg_r.msg_len    <= cfg_wdata;
        default:            cfg_r            <= cfg_r;
      endcase
    end
  end

  assign in_full = q_full;

  mfe_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_payload_byte (in_payload_byte),
    .msg_len         (cfg_r.msg_len),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_job           (q_wdata)
  );

  mfe_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  mfe_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_empty          (q_empty),
    .q_rdata          (q_rdata),
    .q_pop            (q_pop),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_encoded_byte (out_encoded_byte),
    .out_run_last     (out_run_last),
    .out_frame_end    (out_frame_end)
  );

  `MFE_ASSERT_NOW(a_frame_end_is_run_last, !out_empty && out_frame_end, out_run_last, "frame end without run last")
  `MFE_ASSERT_NOW(a_no_pop_when_empty, q_pop, !q_empty, "job queue popped while empty")
  `MFE_ASSERT_NEXT(a_push_lands, q_push && !q_pop, !q_empty, "pushed job missing from queue")

endmodule

// ===== hdl/mfe_front.sv =====
module mfe_front import mfe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_payload_byte,
  input  logic [7:0] msg_len,
  input  logic       q_full,
  output logic       q_push,
  output mfe_job_t   q_job
);

  logic [7:0]  bytes_seen_r, bytes_seen_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  len;
  logic [15:0] crc_base;
  logic [15:0] crc_new;
  logic        tail;

  assign len      = eff_len(msg_len);
  assign crc_base = (bytes_seen_r == 8'd0) ? CRC_INIT : crc_r;
  assign crc_new  = crc_update(crc_base, in_payload_byte);
  assign tail     = ({1'b0, bytes_seen_r} + 9'd1) >= {1'b0, len};
  assign q_push   = in_push & ~q_full;

  always_comb begin
    q_job.payload = in_payload_byte;
    q_job.hdr     = (bytes_seen_r == 8'd0);
    q_job.tail    = tail;
    q_job.crc     = crc_new;
  end

  always_comb begin
    bytes_seen_nxt = bytes_seen_r;
    crc_nxt        = crc_r;
    if (q_push) begin
      if (tail) begin
        bytes_seen_nxt = 8'd0;
        crc_nxt        = CRC_INIT;
      end else begin
        bytes_seen_nxt = bytes_seen_r + 8'd1;
        crc_nxt        = crc_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r <= 8'd0;
      crc_r        <= CRC_INIT;
    end else begin
      bytes_seen_r <= bytes_seen_nxt;
      crc_r        <= crc_nxt;
    end
  end

endmodule

// ===== hdl/mfe_fifo.sv =====
module mfe_fifo import mfe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  mfe_job_t wdata,
  input  logic     pop,
  output mfe_job_t rdata,
  output logic     full,
  output logic     empty
);

  mfe_job_t           mem_r [QDEPTH];
  logic [QAW-1:0]     wr_ptr_r;
  logic [QAW-1:0]     rd_ptr_r;
  logic [QAW:0]       count_r;
  logic               do_push;
  logic               do_pop;

  assign full    = (count_r == (QAW+1)'(QDEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + QAW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + QAW'(1);
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + (QAW+1)'(1);
        2'b01:   count_r <= count_r - (QAW+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== hdl/mfe_back.sv =====
module mfe_back import mfe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  mfe_cfg_t   cfg,
  input  logic       q_empty,
  input  mfe_job_t   q_rdata,
  output logic       q_pop,
  input  logic       out_pop,
  output logic       out_empty,
  output logic [7:0] out_encoded_byte,
  output logic       out_run_last,
  output logic       out_frame_end
);

  typedef enum logic [2:0] {
    STEP_PREAMBLE = 3'd0,
    STEP_DELIM    = 3'd1,
    STEP_TYPE     = 3'd2,
    STEP_LEN      = 3'd3,
    STEP_PAYLOAD  = 3'd4,
    STEP_CRC_HI   = 3'd5,
    STEP_CRC_LO   = 3'd6,
    STEP_CLOSE    = 3'd7
  } step_t;

  logic       busy_r, busy_nxt;
  step_t      step_r, step_nxt;
  logic       half_r, half_nxt;
  mfe_job_t   job_r, job_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] enc_r, enc_nxt;
  logic       run_last_r, run_last_nxt;
  logic       frame_end_r, frame_end_nxt;

  mfe_job_t   cur_job;
  step_t      cur_step;
  step_t      last_step;
  logic       cur_half;
  logic       fire;
  logic       is_last;
  logic [7:0] frame_byte;
  logic [3:0] nib;

  // Serve the first beat of a job straight from the queue head.
  assign cur_job   = busy_r ? job_r : q_rdata;
  assign cur_step  = busy_r ? step_r : (q_rdata.hdr ? STEP_PREAMBLE : STEP_PAYLOAD);
  assign cur_half  = busy_r ? half_r : 1'b0;
  assign last_step = cur_job.tail ? STEP_CLOSE : STEP_PAYLOAD;
  assign is_last   = cur_half && (cur_step == last_step);
  assign fire      = (busy_r | ~q_empty) & (~out_valid_r | out_pop);
  assign q_pop     = fire & ~busy_r;

  always_comb begin
    unique case (cur_step)
      STEP_PREAMBLE: frame_byte = cfg.preamble;
      STEP_DELIM:    frame_byte = cfg.delimiter;
      STEP_TYPE:     frame_byte = cfg.type_flags;
      STEP_LEN:      frame_byte = eff_len(cfg.msg_len);
      STEP_PAYLOAD:  frame_byte = cur_job.payload;
      STEP_CRC_HI:   frame_byte = cur_job.crc[15:8];
      STEP_CRC_LO:   frame_byte = cur_job.crc[7:0];
      STEP_CLOSE:    frame_byte = cfg.delimiter;
      default:       frame_byte = cfg.delimiter;
    endcase
  end

  assign nib = cur_half ? frame_byte[3:0] : frame_byte[7:4];

  always_comb begin
    busy_nxt      = busy_r;
    step_nxt      = step_r;
    half_nxt      = half_r;
    job_nxt       = job_r;
    out_valid_nxt = out_valid_r;
    enc_nxt       = enc_r;
    run_last_nxt  = run_last_r;
    frame_end_nxt = frame_end_r;
    if (fire) begin
      job_nxt       = cur_job;
      busy_nxt      = ~is_last;
      if (cur_half) begin
        step_nxt = step_t'(cur_step + 3'd1);
        half_nxt = 1'b0;
      end else begin
        step_nxt = cur_step;
        half_nxt = 1'b1;
      end
      out_valid_nxt = 1'b1;
      enc_nxt       = manch_nibble(nib);
      run_last_nxt  = is_last;
      frame_end_nxt = cur_half && (cur_step == STEP_CLOSE);
    end else if (out_pop) begin
      // drop the delivered beat
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= STEP_PREAMBLE;
      half_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      half_r      <= half_nxt;
      out_valid_r <= out_valid_nxt;
    end
    job_r       <= job_nxt;
    enc_r       <= enc_nxt;
    run_last_r  <= run_last_nxt;
    frame_end_r <= frame_end_nxt;
  end

  assign out_empty        = ~out_valid_r;
  assign out_encoded_byte = enc_r;
  assign out_run_last     = run_last_r;
  assign out_frame_end    = frame_end_r;

endmodule

// ===== dv/tb.sv =====
module tb;
  import mfe_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD = 400;
  localparam int TAIL_CYCLES = 30;
  localparam logic [7:0] CFG_IDX_UNUSED_LO = 8'd4;
  localparam logic [7:0] CFG_IDX_UNUSED_HI = 8'hFF;

  typedef struct packed {
    logic [7:0] code;
    logic       run_last;
    logic       frame_end;
  } line_beat_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_push;
  logic       in_full;
  logic [7:0] in_payload_byte;
  logic       out_empty;
  logic       out_pop;
  logic [7:0] out_encoded_byte;
  logic       out_run_last;
  logic       out_frame_end;
  logic       cfg_wr_en;
  logic [7:0] cfg_index;
  logic [7:0] cfg_wdata;

  // Local copy of the registers and the open frame
  logic [7:0]  hdr_preamble;
  logic [7:0]  hdr_delimiter;
  logic [7:0]  hdr_type_flags;
  logic [7:0]  hdr_msg_len;
  logic [7:0]  frame_pos;
  logic [15:0] frame_crc;

  line_beat_t line_q[$];

  int  errors;
  int  bytes_sent;
  int  beats_seen;
  int  frames_closed;
  int  stall_cycles;
  int  rx_hold;
  bit  steady;

  manchester_frame_encoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_payload_byte  (in_payload_byte),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_encoded_byte (out_encoded_byte),
    .out_run_last     (out_run_last),
    .out_frame_end    (out_frame_end),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] manchester_half(input logic [3:0] nib);
    return {nib[3], ~nib[3], nib[2], ~nib[2], nib[1], ~nib[1], nib[0], ~nib[0]};
  endfunction

  // Bitwise MSB-first form of poly 0x1021
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction

  function automatic void append_frame_byte(input logic [7:0] v);
    line_q.push_back('{manchester_half(v[7:4]), 1'b0, 1'b0});
    line_q.push_back('{manchester_half(v[3:0]), 1'b0, 1'b0});
  endfunction

  function automatic void encode_payload_byte(input logic [7:0] b);
    logic [7:0] len;
    len = (hdr_msg_len == 8'd0) ? 8'd1 : hdr_msg_len;
    if (frame_pos == 8'd0) begin
      frame_crc = CRC_INIT;
      append_frame_byte(hdr_preamble);
      append_frame_byte(hdr_delimiter);
      append_frame_byte(hdr_type_flags);
      append_frame_byte(len);
    end
    append_frame_byte(b);
    frame_crc = crc16_byte(frame_crc, b);
    if ({1'b0, frame_pos} + 9'd1 >= {1'b0, len}) begin
      append_frame_byte(frame_crc[15:8]);
      append_frame_byte(frame_crc[7:0]);
      append_frame_byte(hdr_delimiter);
      line_q[line_q.size() - 1].frame_end = 1'b1;
      frame_pos = 8'd0;
      frame_crc = CRC_INIT;
    end else begin
      frame_pos = frame_pos + 8'd1;
    end
    line_q[line_q.size() - 1].run_last = 1'b1;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_len();
    return ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 10));
  endfunction

  // Entered and left on a rising edge; in_push stays high after the beat is taken
  task automatic send_byte(input logic [7:0] b);
    bit taken;
    if (!steady && $urandom_range(0, 5) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_payload_byte <= b;
    do begin
      @(negedge clk);
      taken = !in_full;
      if (taken) begin
        encode_payload_byte(b);
        bytes_sent++;
      end
      @(posedge clk);
    end while (!taken);
  endtask

  // Drop the input and wait until every expected beat has left the block
  task automatic settle();
    in_push <= 1'b0;
    while (line_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_IDX_PREAMBLE:   hdr_preamble = val;
      CFG_IDX_DELIMITER:  hdr_delimiter = val;
      CFG_IDX_TYPE_FLAGS: hdr_type_flags = val;
      CFG_IDX_MSG_LEN:    hdr_msg_len = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic test_default_registers();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    send_byte(8'h5A);
  endtask

  task automatic test_header_extremes();
    settle();
    write_reg(CFG_IDX_PREAMBLE, 8'h00);
    write_reg(CFG_IDX_DELIMITER, 8'hFF);
    write_reg(CFG_IDX_TYPE_FLAGS, 8'hFF);
    write_reg(CFG_IDX_MSG_LEN, 8'd3);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'h7F);
    settle();
    write_reg(CFG_IDX_PREAMBLE, 8'hFF);
    write_reg(CFG_IDX_DELIMITER, 8'h00);
    write_reg(CFG_IDX_TYPE_FLAGS, 8'h00);
    write_reg(CFG_IDX_MSG_LEN, 8'd2);
    send_byte(8'hFE);
    send_byte(8'h10);
  endtask

  task automatic test_zero_length();
    settle();
    write_reg(CFG_IDX_MSG_LEN, 8'd0);
    send_byte(8'h3C);
    send_byte(8'hC3);
  endtask

  task automatic test_length_change_mid_frame();
    settle();
    write_reg(CFG_IDX_DELIMITER, 8'h7E);
    write_reg(CFG_IDX_MSG_LEN, 8'd5);
    send_byte(8'h11);
    send_byte(8'h22);
    // shrink to the count already sent: next byte closes the frame
    settle();
    write_reg(CFG_IDX_MSG_LEN, 8'd2);
    send_byte(8'h33);
    settle();
    send_byte(8'h44);
    // grow the open frame and swap the closing delimiter
    settle();
    write_reg(CFG_IDX_MSG_LEN, 8'd4);
    write_reg(CFG_IDX_DELIMITER, 8'h3C);
    send_byte(8'h55);
    send_byte(8'h66);
    send_byte(8'h77);
  endtask

  task automatic test_unknown_index();
    settle();
    write_reg(CFG_IDX_MSG_LEN, 8'd1);
    write_reg(CFG_IDX_UNUSED_LO, 8'hFF);
    write_reg(CFG_IDX_UNUSED_HI, 8'h00);
    send_byte(8'h96);
  endtask

  task automatic test_longest_frame();
    settle();
    write_reg(CFG_IDX_PREAMBLE, pick_byte());
    write_reg(CFG_IDX_DELIMITER, pick_byte());
    write_reg(CFG_IDX_TYPE_FLAGS, pick_byte());
    write_reg(CFG_IDX_MSG_LEN, 8'd255);
    repeat (255) send_byte(pick_byte());
  endtask

  task automatic test_backpressure();
    settle();
    write_reg(CFG_IDX_MSG_LEN, 8'd3);
    @(negedge clk);
    rx_hold = LONG_HOLD;
    @(posedge clk);
    repeat (15) send_byte(pick_byte());
  endtask

  task automatic test_random_frames(input int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      settle();
      write_reg(CFG_IDX_PREAMBLE, pick_byte());
      write_reg(CFG_IDX_DELIMITER, pick_byte());
      write_reg(CFG_IDX_TYPE_FLAGS, pick_byte());
      write_reg(CFG_IDX_MSG_LEN, pick_len());
      if ($urandom_range(0, 7) == 0) begin
        write_reg($urandom_range(0, 1) ? CFG_IDX_UNUSED_LO : CFG_IDX_UNUSED_HI, pick_byte());
      end
      do begin
        send_byte(pick_byte());
        sent++;
        if (frame_pos != 8'd0 && $urandom_range(0, 9) == 0) begin
          settle();
          write_reg(CFG_IDX_MSG_LEN, pick_len());
          if ($urandom_range(0, 1)) write_reg(CFG_IDX_DELIMITER, pick_byte());
        end
      end while (frame_pos != 8'd0);
    end
  endtask

  task automatic test_back_to_back();
    settle();
    steady = 1'b1;
    test_random_frames(40);
  endtask

  // Receiver: random stalls, plus one long hold requested by the pressure test
  initial begin : rx_side
    int hold;
    out_pop = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (rx_hold != 0) begin
        out_pop <= 1'b0;
        hold = rx_hold;
        rx_hold = 0;
        repeat (hold) @(posedge clk);
        out_pop <= 1'b1;
      end else if (!steady && $urandom_range(0, 7) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_pop <= 1'b1;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Sample mid-cycle: the beat is taken at the next rising edge
  always @(negedge clk) begin : beat_check
    line_beat_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (line_q.size() == 0) begin
        errors++;
        $display("%0t: beat with nothing expected: code=%h run_last=%b frame_end=%b",
                 $time, out_encoded_byte, out_run_last, out_frame_end);
      end else begin
        want = line_q.pop_front();
        if (out_encoded_byte !== want.code) begin
          errors++;
          $display("%0t: encoded_byte expected %h actual %h", $time, want.code,
                   out_encoded_byte);
        end
        if (out_run_last !== want.run_last) begin
          errors++;
          $display("%0t: run_last expected %b actual %b", $time, want.run_last,
                   out_run_last);
        end
        if (out_frame_end !== want.frame_end) begin
          errors++;
          $display("%0t: frame_end expected %b actual %b", $time, want.frame_end,
                   out_frame_end);
        end
      end
      beats_seen++;
      if (out_frame_end === 1'b1) frames_closed++;
    end
  end

  always @(negedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles, %0d beats still expected",
               $time, stall_cycles, line_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    errors = 0;
    bytes_sent = 0;
    beats_seen = 0;
    frames_closed = 0;
    stall_cycles = 0;
    rx_hold = 0;
    steady = 1'b0;
    hdr_preamble = 8'h55;
    hdr_delimiter = 8'h7E;
    hdr_type_flags = 8'h00;
    hdr_msg_len = 8'd1;
    frame_pos = 8'd0;
    frame_crc = CRC_INIT;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_payload_byte = 8'h00;
    cfg_wr_en = 1'b0;
    cfg_index = 8'h00;
    cfg_wdata = 8'h00;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_default_registers();
    test_header_extremes();
    test_zero_length();
    test_length_change_mid_frame();
    test_unknown_index();
    test_longest_frame();
    test_backpressure();
    test_random_frames(100);
    test_back_to_back();

    in_push <= 1'b0;
    while (line_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Encoded %0d payload bytes into %0d line beats over %0d closed frames,",
             bytes_sent, beats_seen, frames_closed);
    $display("with header extremes, zero and mid-frame length changes and a long stall.");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
